@@ design/tcbh_pkg.sv @@
// ----------------------------------------------------------------------------
// tcbh_pkg
// Shared types and constants for the touch calibration and button hit core.
// ----------------------------------------------------------------------------
`default_nettype none
package tcbh_pkg;

	localparam int MAX_BUTTONS_DEF   = 16;
	localparam int SCREEN_WIDTH_DEF  = 320;
	localparam int SCREEN_HEIGHT_DEF = 240;
	localparam logic [11:0] TOUCH_THRESHOLD = 12'd10;

	localparam int NUM_W = 21;
	localparam int DEN_W = 12;

	localparam logic [2:0] OP_SAMPLE = 3'd0;
	localparam logic [2:0] OP_ADD    = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_SETEN  = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	localparam logic [3:0] REG_RAW_X_LOW     = 4'd0;
	localparam logic [3:0] REG_RAW_Y_LOW     = 4'd1;
	localparam logic [3:0] REG_RAW_X_HIGH    = 4'd2;
	localparam logic [3:0] REG_RAW_Y_HIGH    = 4'd3;
	localparam logic [3:0] REG_SCREEN_X_LOW  = 4'd4;
	localparam logic [3:0] REG_SCREEN_Y_LOW  = 4'd5;
	localparam logic [3:0] REG_SCREEN_X_HIGH = 4'd6;
	localparam logic [3:0] REG_SCREEN_Y_HIGH = 4'd7;

	typedef struct packed {
		logic [2:0]        op;
		logic [11:0]       raw_x;
		logic [11:0]       raw_y;
		logic [11:0]       pressure;
		logic [8:0]        rect_left;
		logic [8:0]        rect_top;
		logic [8:0]        rect_width;
		logic [8:0]        rect_height;
		logic signed [7:0] rect_tag;
		logic [3:0]        entry_index;
		logic              enable_value;
	} in_word_t;

	typedef struct packed {
		logic              touched;
		logic [8:0]        pos_x;
		logic [7:0]        pos_y;
		logic              press_event;
		logic [3:0]        hit_entry;
		logic              tag_valid;
		logic signed [7:0] hit_tag;
		logic              release_event;
		logic              op_ok;
	} out_word_t;

	typedef struct packed {
		logic [8:0]        left;
		logic [8:0]        top;
		logic [8:0]        width;
		logic [8:0]        height;
		logic signed [7:0] tag;
		logic              enabled;
		logic              pressed;
	} entry_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic set_en;
		logic en_val;
		logic press;
		logic clr_press;
	} cell_ctrl_t;

endpackage
`default_nettype wire

@@ design/tcbh_div.sv @@
// ----------------------------------------------------------------------------
// tcbh_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tcbh_div #(
	parameter int NW = 21,
	parameter int DW = 12
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quo
);
	localparam int CNT_W = $clog2(NW + 1);

	logic [DW-1:0]    rem_q;
	logic [NW-1:0]    num_q;
	logic [DW-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic             fits;

	assign trial = {rem_q, num_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			num_q <= {num_q[NW-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1)) && !start;
			if (start)
				cnt_q <= CNT_W'(NW);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign done = done_q;
	assign quo  = num_q;
endmodule
`default_nettype wire

@@ design/tcbh_cell.sv @@
// ----------------------------------------------------------------------------
// tcbh_cell
// One button entry of the table; takes its neighbour's entry on a remove.
// ----------------------------------------------------------------------------
`default_nettype none
module tcbh_cell (
	input  wire logic                clk,
	input  wire tcbh_pkg::cell_ctrl_t ctrl,
	input  wire tcbh_pkg::entry_t    new_entry,
	input  wire tcbh_pkg::entry_t    nxt_entry,
	input  wire logic [8:0]          pt_x,
	input  wire logic [8:0]          pt_y,
	output tcbh_pkg::entry_t         entry,
	output logic                     hit
);
	import tcbh_pkg::*;

	entry_t    entry_q;
	logic      hit_q;
	logic [9:0] right;
	logic [9:0] bottom;

	assign right  = {1'b0, entry_q.left} + {1'b0, entry_q.width};
	assign bottom = {1'b0, entry_q.top} + {1'b0, entry_q.height};

	always_ff @(posedge clk) begin
		hit_q <= (pt_x >= entry_q.left) && ({1'b0, pt_x} <= right) &&
			(pt_y >= entry_q.top) && ({1'b0, pt_y} <= bottom);
		if (ctrl.load) begin
			entry_q <= new_entry;
		end else if (ctrl.shift) begin
			entry_q <= nxt_entry;
		end else begin
			if (ctrl.set_en)
				entry_q.enabled <= ctrl.en_val;
			if (ctrl.press)
				entry_q.pressed <= 1'b1;
			else if (ctrl.clr_press)
				entry_q.pressed <= 1'b0;
		end
	end

	assign entry = entry_q;
	assign hit   = hit_q;
endmodule
`default_nettype wire

@@ design/touch_calibrate_button_hit_core.sv @@
// ----------------------------------------------------------------------------
// touch_calibrate_button_hit_core
// Touch calibration and button hit test over a chain of button cells.
// ----------------------------------------------------------------------------
// Usage: present a word on in_word with start; it is taken when busy is low.
// busy stays high until the result word appears on result with done high for
// one cycle; the receiver cannot stall, so it must take it then.
// Table edits and released/no-touch samples finish in ST_EXEC, with no divide.
// A touched sample runs two 21-step dividers in parallel (X and Y) and
// returns after the divide when already touching; on a new touch it then
// scans the cells in order until the first hit or the end of the table.
// The divider's bit-per-cycle loop and the cell scan set the latency.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high and writes are expected only while idle.
// Reset restores the calibration defaults, empties the table and clears the
// touch state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module touch_calibrate_button_hit_core #(
	parameter int MAX_BUTTONS   = tcbh_pkg::MAX_BUTTONS_DEF,
	parameter int SCREEN_WIDTH  = tcbh_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = tcbh_pkg::SCREEN_HEIGHT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire tcbh_pkg::in_word_t in_word,
	output logic                    busy,
	output logic                    done,
	output tcbh_pkg::out_word_t     result,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [3:0]         cfg_index,
	input  wire logic [11:0]        cfg_data
);
	import tcbh_pkg::*;

	localparam int IW = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
	localparam int CW = $clog2(MAX_BUTTONS + 1);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_EXEC  = 6'b000010,
		ST_DLOAD = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_CMP   = 6'b010000,
		ST_SCAN  = 6'b100000
	} state_t;

	state_t    state_q;
	in_word_t  in_q;
	out_word_t res_q;
	logic      done_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] scan_q;
	logic      was_touching_q;

	logic [11:0] rxl_q, ryl_q, rxh_q, ryh_q;
	logic [8:0]  sxl_q, syl_q, sxh_q, syh_q;

	logic signed [22:0] prod_x_q, prod_y_q;
	logic signed [12:0] span_x_q, span_y_q;
	logic [8:0]  pos_x_q, pos_y_q;

	// config
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rxl_q <= 12'd0;
			ryl_q <= 12'd0;
			rxh_q <= 12'd4095;
			ryh_q <= 12'd4095;
			sxl_q <= 9'd0;
			syl_q <= 9'd0;
			sxh_q <= 9'd320;
			syh_q <= 9'd240;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RAW_X_LOW:     rxl_q <= cfg_data;
				REG_RAW_Y_LOW:     ryl_q <= cfg_data;
				REG_RAW_X_HIGH:    rxh_q <= cfg_data;
				REG_RAW_Y_HIGH:    ryh_q <= cfg_data;
				REG_SCREEN_X_LOW:  sxl_q <= cfg_data[8:0];
				REG_SCREEN_Y_LOW:  syl_q <= cfg_data[8:0];
				REG_SCREEN_X_HIGH: sxh_q <= cfg_data[8:0];
				REG_SCREEN_Y_HIGH: syh_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// mapping arithmetic
	logic signed [12:0] dx, dy;
	logic signed [9:0]  sdx, sdy;
	assign dx  = $signed({1'b0, in_q.raw_x}) - $signed({1'b0, rxl_q});
	assign dy  = $signed({1'b0, in_q.raw_y}) - $signed({1'b0, ryl_q});
	assign sdx = $signed({1'b0, sxh_q}) - $signed({1'b0, sxl_q});
	assign sdy = $signed({1'b0, syh_q}) - $signed({1'b0, syl_q});

	logic signed [22:0] abs_px, abs_py;
	logic signed [12:0] abs_sx, abs_sy;
	assign abs_px = prod_x_q[22] ? -prod_x_q : prod_x_q;
	assign abs_py = prod_y_q[22] ? -prod_y_q : prod_y_q;
	assign abs_sx = span_x_q[12] ? -span_x_q : span_x_q;
	assign abs_sy = span_y_q[12] ? -span_y_q : span_y_q;

	logic div_start, done_x, done_y, div_done;
	logic [NUM_W-1:0] quo_x, quo_y;
	assign div_start = (state_q == ST_DLOAD);
	assign div_done  = done_x && done_y;

	tcbh_div #(.NW(NUM_W), .DW(DEN_W)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(abs_px[NUM_W-1:0]), .den(abs_sx[DEN_W-1:0]),
		.done(done_x), .quo(quo_x)
	);
	tcbh_div #(.NW(NUM_W), .DW(DEN_W)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(abs_py[NUM_W-1:0]), .den(abs_sy[DEN_W-1:0]),
		.done(done_y), .quo(quo_y)
	);

	logic signed [22:0] qx, qy, vx, vy;
	logic [8:0] cx, cy;
	always_comb begin
		qx = $signed({2'b00, quo_x});
		qy = $signed({2'b00, quo_y});
		if (prod_x_q[22] ^ span_x_q[12])
			qx = -qx;
		if (prod_y_q[22] ^ span_y_q[12])
			qy = -qy;
		if (span_x_q == '0)
			qx = '0;
		if (span_y_q == '0)
			qy = '0;
		vx = qx + $signed({14'd0, sxl_q});
		vy = qy + $signed({14'd0, syl_q});
		if (vx < 0)
			cx = '0;
		else if (vx > 23'(SCREEN_WIDTH - 1))
			cx = 9'(SCREEN_WIDTH - 1);
		else
			cx = vx[8:0];
		if (vy < 0)
			cy = '0;
		else if (vy > 23'(SCREEN_HEIGHT - 1))
			cy = 9'(SCREEN_HEIGHT - 1);
		else
			cy = vy[8:0];
	end

	// cell chain
	entry_t     entries [MAX_BUTTONS];
	logic       hits    [MAX_BUTTONS];
	cell_ctrl_t ctrls   [MAX_BUTTONS];
	logic [MAX_BUTTONS-1:0] live_pressed;
	entry_t     new_entry;

	logic is_add, is_rem, is_set, is_sample, touch_now, idx_ok, add_ok, scan_end;
	assign is_sample = in_q.op == OP_SAMPLE;
	assign is_add    = in_q.op == OP_ADD;
	assign is_rem    = in_q.op == OP_REMOVE;
	assign is_set    = in_q.op == OP_SETEN;
	assign touch_now = in_q.pressure > TOUCH_THRESHOLD;
	assign idx_ok    = 32'(in_q.entry_index) < 32'(count_q);
	assign add_ok    = 32'(count_q) < 32'(MAX_BUTTONS);
	assign scan_end  = scan_q >= count_q;

	assign new_entry = '{left: in_q.rect_left, top: in_q.rect_top,
		width: in_q.rect_width, height: in_q.rect_height, tag: in_q.rect_tag,
		enabled: 1'b1, pressed: 1'b0};

	for (genvar i = 0; i < MAX_BUTTONS; i++) begin : g_cell
		logic ex;
		assign ex = state_q == ST_EXEC;
		assign ctrls[i] = '{
			load:      ex && is_add && add_ok && (32'(count_q) == i),
			shift:     ex && is_rem && idx_ok && (32'(in_q.entry_index) <= i),
			set_en:    ex && is_set && idx_ok && (32'(in_q.entry_index) == i),
			en_val:    in_q.enable_value,
			press:     (state_q == ST_SCAN) && !scan_end &&
				(32'(scan_q) == i) && hits[i] && entries[i].enabled,
			clr_press: ex && is_sample && !touch_now
		};
		assign live_pressed[i] = entries[i].pressed && (32'(count_q) > i);
		tcbh_cell u_cell (
			.clk(clk), .ctrl(ctrls[i]), .new_entry(new_entry),
			.nxt_entry(entries[(i + 1 < MAX_BUTTONS) ? i + 1 : i]),
			.pt_x(pos_x_q), .pt_y(pos_y_q),
			.entry(entries[i]), .hit(hits[i])
		);
	end

	entry_t scan_entry;
	logic   scan_hit;
	assign scan_entry = entries[scan_q[IW-1:0]];
	assign scan_hit   = hits[scan_q[IW-1:0]];

	// control
	always_ff @(posedge clk) begin
		if (start && !busy)
			in_q <= in_word;
		if (state_q == ST_EXEC) begin
			prod_x_q <= 23'(dx * sdx);
			prod_y_q <= 23'(dy * sdy);
			span_x_q <= $signed({1'b0, rxh_q}) - $signed({1'b0, rxl_q});
			span_y_q <= $signed({1'b0, ryh_q}) - $signed({1'b0, ryl_q});
		end
		if (state_q == ST_DIV && div_done) begin
			pos_x_q <= cx;
			pos_y_q <= cy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			done_q         <= 1'b0;
			res_q          <= '0;
			count_q        <= '0;
			scan_q         <= '0;
			was_touching_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					res_q <= '0;
					if (is_sample && touch_now) begin
						state_q <= ST_DLOAD;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						case (in_q.op)
							OP_SAMPLE: begin
								res_q.release_event <= |live_pressed;
								was_touching_q      <= 1'b0;
							end
							OP_ADD: begin
								if (add_ok) begin
									res_q.op_ok     <= 1'b1;
									res_q.hit_entry <= 4'(count_q);
									count_q         <= count_q + CW'(1);
								end
							end
							OP_REMOVE: begin
								if (idx_ok) begin
									res_q.op_ok <= 1'b1;
									count_q     <= count_q - CW'(1);
								end
							end
							OP_SETEN: res_q.op_ok <= idx_ok;
							OP_CLEAR: begin
								res_q.op_ok <= 1'b1;
								count_q     <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_DLOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						res_q.touched  <= 1'b1;
						res_q.pos_x    <= cx;
						res_q.pos_y    <= cy[7:0];
						was_touching_q <= 1'b1;
						scan_q         <= '0;
						if (was_touching_q) begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
						end else begin
							state_q <= ST_CMP;
						end
					end
				end
				ST_CMP: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else if (scan_hit) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						if (scan_entry.enabled) begin
							res_q.press_event <= 1'b1;
							res_q.hit_entry   <= 4'(scan_q);
							res_q.tag_valid   <= !scan_entry.tag[7];
							res_q.hit_tag     <= scan_entry.tag;
						end
					end else begin
						scan_q <= scan_q + CW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = res_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= MAX_BUTTONS) else $error("button count overflow");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted word not started");
	a_press_touch: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.press_event |-> result.touched)
		else $error("press without touch");
	a_press_edit: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.op_ok |-> !result.touched && !result.release_event)
		else $error("edit result mixed with sample fields");
endmodule
`default_nettype wire

@@ tb/touch_calibrate_button_hit_checker.sv @@
// ----------------------------------------------------------------------------
// touch_calibrate_button_hit_checker
// Watches the command, configuration and result channels of the core, keeps
// its own copy of the calibration and button table, predicts each result word
// and compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
`default_nettype none
module touch_calibrate_button_hit_checker
	import tcbh_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic      busy,
	input  wire in_word_t  in_word,
	input  wire logic      done,
	input  wire out_word_t result,
	input  wire logic      cfg_valid,
	input  wire logic      cfg_ready,
	input  wire logic [3:0]  cfg_index,
	input  wire logic [11:0] cfg_data,
	output int             fail_count,
	output int             pending,
	output int             checked
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [11:0] rxl, ryl, rxh, ryh;
	logic [8:0]  sxl, syl, sxh, syh;
	entry_t      tbl [MAX_BUTTONS_DEF];
	int          nbtn;
	logic        touching;
	out_word_t   expected_words [$];

	function automatic int cal_map(int v, int il, int ih, int ol, int oh);
		if (ih == il) return ol;
		return (v - il) * (oh - ol) / (ih - il) + ol;
	endfunction

	function automatic int clip(int v, int hi);
		if (v < 0) return 0;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic predict_word(input in_word_t w);
		out_word_t r;
		int x, y;
		r = '0;
		case (w.op)
			OP_SAMPLE: begin
				if (w.pressure > TOUCH_THRESHOLD) begin
					x = clip(cal_map(w.raw_x, rxl, rxh, sxl, sxh), SCREEN_WIDTH_DEF - 1);
					y = clip(cal_map(w.raw_y, ryl, ryh, syl, syh), SCREEN_HEIGHT_DEF - 1);
					r.touched = 1'b1;
					r.pos_x = x[8:0];
					r.pos_y = y[7:0];
					if (!touching) begin
						for (int i = 0; i < nbtn; i++) begin
							if (x >= tbl[i].left && x <= int'(tbl[i].left) + int'(tbl[i].width) &&
								y >= tbl[i].top && y <= int'(tbl[i].top) + int'(tbl[i].height)) begin
								if (tbl[i].enabled) begin
									tbl[i].pressed = 1'b1;
									r.press_event = 1'b1;
									r.hit_entry = i[3:0];
									r.tag_valid = !tbl[i].tag[7];
									r.hit_tag = tbl[i].tag;
								end
								break;
							end
						end
					end
					touching = 1'b1;
				end else begin
					for (int i = 0; i < nbtn; i++)
						if (tbl[i].pressed) begin
							tbl[i].pressed = 1'b0;
							r.release_event = 1'b1;
						end
					touching = 1'b0;
				end
			end
			OP_ADD: begin
				if (nbtn < MAX_BUTTONS_DEF) begin
					tbl[nbtn] = '{w.rect_left, w.rect_top, w.rect_width, w.rect_height,
						w.rect_tag, 1'b1, 1'b0};
					r.hit_entry = nbtn[3:0];
					r.op_ok = 1'b1;
					nbtn++;
				end
			end
			OP_REMOVE: begin
				if (w.entry_index < nbtn) begin
					for (int i = w.entry_index; i + 1 < nbtn; i++) tbl[i] = tbl[i + 1];
					nbtn--;
					r.op_ok = 1'b1;
				end
			end
			OP_SETEN: begin
				if (w.entry_index < nbtn) begin
					tbl[w.entry_index].enabled = w.enable_value;
					r.op_ok = 1'b1;
				end
			end
			OP_CLEAR: begin
				nbtn = 0;
				r.op_ok = 1'b1;
			end
			default: ;
		endcase
		expected_words.push_back(r);
	endtask

	task automatic mismatch(input string f, input int e, input int a);
		$display("%0t: %s mismatch: expected %0d actual %0d", $realtime, f, e, a);
		fail_count++;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rxl <= '0; ryl <= '0; rxh <= 12'd4095; ryh <= 12'd4095;
			sxl <= '0; syl <= '0; sxh <= 9'd320; syh <= 9'd240;
			nbtn = 0;
			touching = 1'b0;
			expected_words.delete();
			fail_count = 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				case (cfg_index)
					REG_RAW_X_LOW:     rxl <= cfg_data;
					REG_RAW_Y_LOW:     ryl <= cfg_data;
					REG_RAW_X_HIGH:    rxh <= cfg_data;
					REG_RAW_Y_HIGH:    ryh <= cfg_data;
					REG_SCREEN_X_LOW:  sxl <= cfg_data[8:0];
					REG_SCREEN_Y_LOW:  syl <= cfg_data[8:0];
					REG_SCREEN_X_HIGH: sxh <= cfg_data[8:0];
					REG_SCREEN_Y_HIGH: syh <= cfg_data[8:0];
					default: ;
				endcase
			if (done) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result word %h", $realtime, result);
					fail_count++;
				end else begin
					out_word_t e;
					e = expected_words.pop_front();
					if (e.touched !== result.touched) mismatch("touched", e.touched, result.touched);
					if (e.pos_x !== result.pos_x) mismatch("pos_x", e.pos_x, result.pos_x);
					if (e.pos_y !== result.pos_y) mismatch("pos_y", e.pos_y, result.pos_y);
					if (e.press_event !== result.press_event)
						mismatch("press_event", e.press_event, result.press_event);
					if (e.hit_entry !== result.hit_entry)
						mismatch("hit_entry", e.hit_entry, result.hit_entry);
					if (e.tag_valid !== result.tag_valid)
						mismatch("tag_valid", e.tag_valid, result.tag_valid);
					if (e.hit_tag !== result.hit_tag) mismatch("hit_tag", e.hit_tag, result.hit_tag);
					if (e.release_event !== result.release_event)
						mismatch("release_event", e.release_event, result.release_event);
					if (e.op_ok !== result.op_ok) mismatch("op_ok", e.op_ok, result.op_ok);
					checked <= checked + 1;
				end
			end
			if (start && !busy) predict_word(in_word);
			pending <= expected_words.size();
		end
	end
endmodule
`default_nettype wire

@@ tb/touch_calibrate_button_hit_core_tb.sv @@
// ----------------------------------------------------------------------------
// touch_calibrate_button_hit_core_tb
// Drives table edits and touch samples into the core through several
// calibration settings, with bursty gaps; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none
module touch_calibrate_button_hit_core_tb;
	import tcbh_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	in_word_t    in_word = '0;
	logic        busy, done, cfg_ready;
	out_word_t   result;
	logic        cfg_valid = 1'b0;
	logic [3:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;
	int          fail_count, pending, checked;
	int          cycles = 0;
	int          words_sent = 0;
	int          cfg_writes = 0;

	touch_calibrate_button_hit_core dut (.*);
	touch_calibrate_button_hit_checker chk (.*);

	initial forever #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_word(input in_word_t w);
		start <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (busy);
		start <= 1'b0;
		words_sent++;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [11:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
		@(posedge clk);
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic in_word_t rand_word(input int mode);
		in_word_t w;
		int r;
		w = in_word_t'(100'({$urandom, $urandom, $urandom, $urandom}));
		r = $urandom_range(0, 99);
		if (mode == 0) begin
			if (r < 55) w.op = OP_SAMPLE;
			else if (r < 75) w.op = OP_ADD;
			else if (r < 83) w.op = OP_REMOVE;
			else if (r < 93) w.op = OP_SETEN;
			else if (r < 96) w.op = OP_CLEAR;
			if (w.op == OP_SAMPLE && $urandom_range(0, 2) == 0)
				w.pressure = 12'($urandom_range(0, 15));
			if (w.op == OP_ADD) begin
				w.rect_left = 9'($urandom_range(0, 300));
				w.rect_top = 9'($urandom_range(0, 220));
				w.rect_width = $urandom_range(0, 1) ? 9'($urandom_range(0, 120)) : w.rect_width;
				w.rect_height = $urandom_range(0, 1) ? 9'($urandom_range(0, 120)) :
					w.rect_height;
			end
			if ($urandom_range(0, 1)) w.entry_index = 4'($urandom_range(0, 3));
		end
		return w;
	endfunction

	task automatic directed();
		in_word_t w;
		w = '0;
		w.op = OP_SAMPLE; w.pressure = 12'd10; send_word(w);
		w.op = OP_REMOVE; send_word(w);
		w.op = OP_SETEN; send_word(w);
		w.op = OP_ADD; w.rect_left = 9'd0; w.rect_top = 9'd0;
		w.rect_width = 9'd511; w.rect_height = 9'd511; w.rect_tag = -8'sd128; send_word(w);
		w.rect_left = 9'd10; w.rect_width = 9'd5; w.rect_tag = 8'sd127; send_word(w);
		w.op = OP_SAMPLE; w.pressure = 12'd11; w.raw_x = 12'd0; w.raw_y = 12'd0; send_word(w);
		w.pressure = 12'd4095; w.raw_x = 12'd4095; w.raw_y = 12'd4095; send_word(w);
		w.pressure = 12'd0; send_word(w);
		w.op = OP_SETEN; w.entry_index = 4'd0; w.enable_value = 1'b0; send_word(w);
		w.op = OP_SAMPLE; w.pressure = 12'd500; w.raw_x = 12'd160; send_word(w);
		w.pressure = 12'd0; send_word(w);
		w.op = OP_SETEN; w.entry_index = 4'd15; send_word(w);
		w.op = OP_REMOVE; w.entry_index = 4'd0; send_word(w);
		w.op = 3'd5; send_word(w);
		w.op = 3'd7; send_word(w);
		w.op = OP_ADD;
		repeat (17) send_word(w);
		w.op = OP_CLEAR; send_word(w);
	endtask

	task automatic set_cal(input logic [11:0] a, b, c, d, input logic [8:0] e, f, g, h);
		write_reg(REG_RAW_X_LOW, a); write_reg(REG_RAW_Y_LOW, b);
		write_reg(REG_RAW_X_HIGH, c); write_reg(REG_RAW_Y_HIGH, d);
		write_reg(REG_SCREEN_X_LOW, {3'b0, e}); write_reg(REG_SCREEN_Y_LOW, {3'b0, f});
		write_reg(REG_SCREEN_X_HIGH, {3'b0, g}); write_reg(REG_SCREEN_Y_HIGH, {3'b0, h});
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: set_cal(12'd0, 12'd0, 12'd4095, 12'd4095, 9'd0, 9'd0, 9'd320, 9'd240);
				1: set_cal(12'd4095, 12'd4095, 12'd0, 12'd0, 9'd511, 9'd511, 9'd0, 9'd0);
				2: set_cal(12'd200, 12'd300, 12'd200, 12'd300, 9'd100, 9'd77, 9'd5, 9'd6);
				3: set_cal(12'd300, 12'd250, 12'd3800, 12'd3700, 9'd0, 9'd0, 9'd319, 9'd239);
				4: set_cal(12'd3800, 12'd200, 12'd200, 12'd3900, 9'd319, 9'd0, 9'd0, 9'd239);
				default: set_cal(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
					9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom));
			endcase
			for (int n = 0; n < 285; ) begin
				int burst;
				burst = $urandom_range(1, 20);
				for (int k = 0; k < burst && n < 285; k++, n++)
					send_word(rand_word($urandom_range(0, 19) == 0));
				if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
		drain();
		$display("%0d command words, %0d register writes, %0d results checked",
			words_sent, cfg_writes, checked);
		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
design/tcbh_pkg.sv
design/tcbh_div.sv
design/tcbh_cell.sv
design/touch_calibrate_button_hit_core.sv
tb/touch_calibrate_button_hit_checker.sv
tb/touch_calibrate_button_hit_core_tb.sv
